>>> hdl/cmlp_pkg.sv
// Shared types and constants of the cascaded motor control loop.
// Payload structs, register indexes, mode codes, controller states and the
// command/status structs between controller and datapath. No dependencies.
package cmlp_pkg;

  // Register file
  localparam int unsigned NUM_CFG   = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_LIMIT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_RAMP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_RAMP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_FF_GAIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_POSITION_GAIN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_GAIN  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_GAIN  = 3'd7;

  // Request op and mode codes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_RESET = 1'b1;

  localparam logic [2:0] MODE_CURRENT      = 3'd0;
  localparam logic [2:0] MODE_CURRENT_RAMP = 3'd1;
  localparam logic [2:0] MODE_VELOCITY     = 3'd2;
  localparam logic [2:0] MODE_VEL_RAMP     = 3'd3;
  localparam logic [2:0] MODE_POSITION     = 3'd4;

  // Multiplier digit width (one W x MUL_DIGIT_W partial product per cycle)
  localparam int unsigned MUL_DIGIT_W = 16;

  typedef struct packed {
    logic               op;
    logic [2:0]         mode;
    logic signed [31:0] current_demand;
    logic signed [31:0] velocity_demand;
    logic signed [31:0] target_position;
    logic signed [31:0] measured_velocity;
    logic signed [31:0] measured_position;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] current_command;
    logic               saturated;
    logic signed [31:0] integrator_value;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_SETPT,
    ST_DIFF,
    ST_STEP,
    ST_FF_GO,
    ST_FF_WAIT,
    ST_PERR,
    ST_PG_GO,
    ST_PG_WAIT,
    ST_VCLAMP,
    ST_VERR,
    ST_VG_GO,
    ST_VG_WAIT,
    ST_ADDI,
    ST_SAT,
    ST_IG_GO,
    ST_IG_WAIT,
    ST_OUT
  } state_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_RESET_OP,
    DP_CLAMP,
    DP_SETPT,
    DP_DIFF,
    DP_STEP,
    DP_FF_MUL,
    DP_FF_WR,
    DP_PERR,
    DP_PG_MUL,
    DP_PG_WR,
    DP_VCLAMP,
    DP_VERR,
    DP_VG_MUL,
    DP_VG_WR,
    DP_ADD_INT,
    DP_SAT,
    DP_IG_MUL,
    DP_IG_WR,
    DP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   sel_vel;
  } ctl_cmd_t;

  typedef struct packed {
    logic       item_op;
    logic [2:0] mode;
    logic       mul_done;
    logic       sat_hit;
  } ctl_stat_t;

endpackage

>>> hdl/cmlp_mul.sv
// Sequential saturating Q-format multiplier: one W x 16 partial product per cycle.
// Result is (a*b) >> F truncated toward zero, saturated to W bits.
// Depends on cmlp_pkg.
module cmlp_mul #(
  parameter int unsigned W = 32,
  parameter int unsigned F = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [W-1:0] a,
  input  logic signed [W-1:0] b,
  output logic                done,
  output logic signed [W-1:0] result
);

  localparam int unsigned DW   = cmlp_pkg::MUL_DIGIT_W;
  localparam int unsigned NDIG = (W + DW - 1) / DW;
  localparam int unsigned BW   = NDIG * DW;
  localparam int unsigned PW   = W + BW;
  localparam int unsigned CW   = $clog2(NDIG + 1);

  localparam logic [PW-1:0] LIM_POS = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [PW-1:0] LIM_NEG = LIM_POS + 1'b1;

  logic          busy_r, busy_nxt;
  logic          fin_r, fin_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  a_r, a_nxt;
  logic [BW-1:0] b_r, b_nxt;
  logic          neg_r, neg_nxt;
  logic [PW-1:0] acc_r, acc_nxt;
  logic signed [W-1:0] res_r, res_nxt;

  logic [W-1:0]    mag_a, mag_b;
  logic [W+DW-1:0] part;
  logic [PW-1:0]   mag, lim, mag_c;

  assign mag_a = a[W-1] ? (~a + 1'b1) : a;
  assign mag_b = b[W-1] ? (~b + 1'b1) : b;
  assign part  = a_r * b_r[BW-1 -: DW];
  assign mag   = acc_r >> F;
  assign lim   = neg_r ? LIM_NEG : LIM_POS;
  assign mag_c = (mag > lim) ? lim : mag;

  always_comb begin
    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    neg_nxt  = neg_r;
    acc_nxt  = acc_r;
    res_nxt  = res_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NDIG);
      a_nxt    = mag_a;
      b_nxt    = BW'(mag_b);
      neg_nxt  = a[W-1] ^ b[W-1];
      acc_nxt  = '0;
    end else if (busy_r) begin
      // most significant digit first: shift the partial sum, add the next product
      acc_nxt = (acc_r << DW) + PW'(part);
      b_nxt   = b_r << DW;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end else if (fin_r) begin
      res_nxt  = neg_r ? (~mag_c[W-1:0] + 1'b1) : mag_c[W-1:0];
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    neg_r <= neg_nxt;
    acc_r <= acc_nxt;
    res_r <= res_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

>>> hdl/cmlp_datapath.sv
// Datapath of the motor control loop: register file, captured request, setpoints,
// integrator, saturating add/clamp logic and the output register.
// Depends on cmlp_pkg and cmlp_mul.
module cmlp_datapath #(
  parameter int unsigned W = 32,
  parameter int unsigned F = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  cmlp_pkg::ctl_cmd_t                 cmd,
  output cmlp_pkg::ctl_stat_t                stat,
  input  cmlp_pkg::in_item_t                 in_data,
  input  logic                               cfg_we,
  input  logic [cmlp_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [cmlp_pkg::CFG_W-1:0]         cfg_wdata,
  output cmlp_pkg::out_item_t                out_data
);

  localparam logic signed [W-1:0]  VMAX   = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  VMIN   = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [63:0]   VMAX64 = (64'sd1 <<< (W-1)) - 64'sd1;
  localparam logic signed [63:0]   VMIN64 = -VMAX64 - 64'sd1;
  localparam logic [63:0]          VMAXU  = VMAX64;

  function automatic logic signed [W-1:0] sat_wide(input logic [W:0] s);
    if (s[W] != s[W-1]) begin
      return s[W] ? VMIN : VMAX;
    end
    return s[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] add_s(input logic signed [W-1:0] x,
                                                input logic signed [W-1:0] y);
    return sat_wide({x[W-1], x} + {y[W-1], y});
  endfunction

  function automatic logic signed [W-1:0] sub_s(input logic signed [W-1:0] x,
                                                input logic signed [W-1:0] y);
    return sat_wide({x[W-1], x} - {y[W-1], y});
  endfunction

  function automatic logic signed [W-1:0] clamp_sym(input logic signed [W-1:0] v,
                                                    input logic signed [W-1:0] lim);
    logic signed [W-1:0] nl;
    nl = -lim;
    if (v > lim) return lim;
    if (v < nl) return nl;
    return v;
  endfunction

  function automatic logic signed [W-1:0] in_conv(input logic [31:0] x);
    logic signed [63:0] t;
    t = {{32{x[31]}}, x};
    if (t > VMAX64) return VMAX;
    if (t < VMIN64) return VMIN;
    return t[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] cfg_conv(input logic [cmlp_pkg::CFG_W-1:0] x);
    logic [63:0] t;
    t = {{(64-cmlp_pkg::CFG_W){1'b0}}, x};
    if (t > VMAXU) return VMAX;
    return t[W-1:0];
  endfunction

  function automatic logic [31:0] to_out(input logic signed [W-1:0] v);
    logic [63:0] t;
    t = {{(64-W){v[W-1]}}, v};
    return t[31:0];
  endfunction

  // Registers with reset: configuration and controller state
  logic signed [W-1:0] cfg_r [cmlp_pkg::NUM_CFG];
  logic signed [W-1:0] pos_sp_r, pos_sp_nxt;
  logic signed [W-1:0] vel_sp_r, vel_sp_nxt;
  logic signed [W-1:0] cur_sp_r, cur_sp_nxt;
  logic signed [W-1:0] integ_r, integ_nxt;

  // Working registers
  logic                op_r, op_nxt;
  logic [2:0]          mode_r, mode_nxt;
  logic signed [W-1:0] tc_r, tc_nxt, tv_r, tv_nxt, tp_r, tp_nxt;
  logic signed [W-1:0] mv_r, mv_nxt, mp_r, mp_nxt;
  logic signed [W-1:0] tclamp_r, tclamp_nxt;
  logic signed [W-1:0] diff_r, diff_nxt;
  logic signed [W-1:0] step_r, step_nxt;
  logic signed [W-1:0] vdes_r, vdes_nxt;
  logic signed [W-1:0] verr_r, verr_nxt;
  logic signed [W-1:0] cmd_r, cmd_nxt;
  logic                satd_r, satd_nxt;
  cmlp_pkg::out_item_t out_r, out_nxt;

  logic signed [W-1:0] lim_i, lim_v;
  logic signed [W-1:0] sp_sel, tgt_sel, lim_sel, rs_sel;
  logic signed [W-1:0] step_calc, nsp, neg_lim;
  logic                sat_hi, sat_lo;
  logic                mul_start, mul_done;
  logic signed [W-1:0] mul_a, mul_b, mul_res;

  assign lim_i   = cfg_r[cmlp_pkg::CFG_CURRENT_LIMIT];
  assign lim_v   = cfg_r[cmlp_pkg::CFG_VELOCITY_LIMIT];
  assign sp_sel  = cmd.sel_vel ? vel_sp_r : cur_sp_r;
  assign tgt_sel = cmd.sel_vel ? tv_r : tc_r;
  assign lim_sel = cmd.sel_vel ? lim_v : lim_i;
  assign rs_sel  = cmd.sel_vel ? cfg_r[cmlp_pkg::CFG_VELOCITY_RAMP]
                               : cfg_r[cmlp_pkg::CFG_CURRENT_RAMP];
  assign step_calc = clamp_sym(diff_r, rs_sel);
  assign nsp       = add_s(sp_sel, step_calc);
  assign neg_lim   = -lim_i;
  assign sat_hi    = cmd_r > lim_i;
  assign sat_lo    = cmd_r < neg_lim;

  // Multiplier operand select
  always_comb begin
    mul_start = 1'b1;
    mul_a     = verr_r;
    mul_b     = cfg_r[cmlp_pkg::CFG_INTEGRAL_GAIN];
    unique case (cmd.op)
      cmlp_pkg::DP_FF_MUL: begin
        mul_a = step_r;
        mul_b = cfg_r[cmlp_pkg::CFG_ACCEL_FF_GAIN];
      end
      cmlp_pkg::DP_PG_MUL: begin
        mul_a = diff_r;
        mul_b = cfg_r[cmlp_pkg::CFG_POSITION_GAIN];
      end
      cmlp_pkg::DP_VG_MUL: begin
        mul_a = verr_r;
        mul_b = cfg_r[cmlp_pkg::CFG_VELOCITY_GAIN];
      end
      cmlp_pkg::DP_IG_MUL: begin
        mul_a = verr_r;
        mul_b = cfg_r[cmlp_pkg::CFG_INTEGRAL_GAIN];
      end
      default: mul_start = 1'b0;
    endcase
  end

  cmlp_mul #(
    .W (W),
    .F (F)
  ) u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .result (mul_res)
  );

  always_comb begin
    pos_sp_nxt = pos_sp_r;
    vel_sp_nxt = vel_sp_r;
    cur_sp_nxt = cur_sp_r;
    integ_nxt  = integ_r;
    op_nxt     = op_r;
    mode_nxt   = mode_r;
    tc_nxt     = tc_r;
    tv_nxt     = tv_r;
    tp_nxt     = tp_r;
    mv_nxt     = mv_r;
    mp_nxt     = mp_r;
    tclamp_nxt = tclamp_r;
    diff_nxt   = diff_r;
    step_nxt   = step_r;
    vdes_nxt   = vdes_r;
    verr_nxt   = verr_r;
    cmd_nxt    = cmd_r;
    satd_nxt   = satd_r;
    out_nxt    = out_r;
    unique case (cmd.op)
      cmlp_pkg::DP_LOAD: begin
        op_nxt   = in_data.op;
        mode_nxt = in_data.mode;
        tc_nxt   = in_conv(in_data.current_demand);
        tv_nxt   = in_conv(in_data.velocity_demand);
        tp_nxt   = in_conv(in_data.target_position);
        mv_nxt   = in_conv(in_data.measured_velocity);
        mp_nxt   = in_conv(in_data.measured_position);
      end
      cmlp_pkg::DP_RESET_OP: begin
        integ_nxt  = '0;
        vel_sp_nxt = '0;
        cur_sp_nxt = '0;
        pos_sp_nxt = mp_r;
        cmd_nxt    = '0;
        satd_nxt   = 1'b0;
      end
      cmlp_pkg::DP_CLAMP: tclamp_nxt = clamp_sym(tgt_sel, lim_sel);
      cmlp_pkg::DP_SETPT: begin
        case (mode_r)
          cmlp_pkg::MODE_CURRENT: begin
            cur_sp_nxt = tclamp_r;
            cmd_nxt    = tclamp_r;
          end
          cmlp_pkg::MODE_VELOCITY: begin
            vel_sp_nxt = tclamp_r;
            vdes_nxt   = tclamp_r;
          end
          cmlp_pkg::MODE_POSITION: pos_sp_nxt = tp_r;
          default: ;
        endcase
      end
      cmlp_pkg::DP_DIFF: diff_nxt = sub_s(tclamp_r, sp_sel);
      cmlp_pkg::DP_STEP: begin
        step_nxt = step_calc;
        if (cmd.sel_vel) begin
          vel_sp_nxt = nsp;
          vdes_nxt   = nsp;
        end else begin
          cur_sp_nxt = nsp;
          cmd_nxt    = nsp;
        end
      end
      cmlp_pkg::DP_FF_WR:   cur_sp_nxt = mul_res;
      cmlp_pkg::DP_PERR:    diff_nxt   = sub_s(pos_sp_r, mp_r);
      cmlp_pkg::DP_PG_WR:   vdes_nxt   = add_s(vel_sp_r, mul_res);
      cmlp_pkg::DP_VCLAMP:  vdes_nxt   = clamp_sym(vdes_r, lim_v);
      cmlp_pkg::DP_VERR:    verr_nxt   = sub_s(vdes_r, mv_r);
      cmlp_pkg::DP_VG_WR:   cmd_nxt    = add_s(cur_sp_r, mul_res);
      cmlp_pkg::DP_ADD_INT: cmd_nxt    = add_s(cmd_r, integ_r);
      cmlp_pkg::DP_SAT: begin
        // at the limit exactly is not saturation
        satd_nxt = sat_hi | sat_lo;
        if (sat_lo) begin
          cmd_nxt = neg_lim;
        end else if (sat_hi) begin
          cmd_nxt = lim_i;
        end
      end
      cmlp_pkg::DP_IG_WR: integ_nxt = add_s(integ_r, mul_res);
      cmlp_pkg::DP_OUT: begin
        out_nxt.current_command  = to_out(cmd_r);
        out_nxt.saturated        = satd_r;
        out_nxt.integrator_value = to_out(integ_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < cmlp_pkg::NUM_CFG; i++) begin
        cfg_r[i] <= '0;
      end
      pos_sp_r <= '0;
      vel_sp_r <= '0;
      cur_sp_r <= '0;
      integ_r  <= '0;
    end else begin
      if (cfg_we) begin
        cfg_r[cfg_addr] <= cfg_conv(cfg_wdata);
      end
      pos_sp_r <= pos_sp_nxt;
      vel_sp_r <= vel_sp_nxt;
      cur_sp_r <= cur_sp_nxt;
      integ_r  <= integ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    mode_r   <= mode_nxt;
    tc_r     <= tc_nxt;
    tv_r     <= tv_nxt;
    tp_r     <= tp_nxt;
    mv_r     <= mv_nxt;
    mp_r     <= mp_nxt;
    tclamp_r <= tclamp_nxt;
    diff_r   <= diff_nxt;
    step_r   <= step_nxt;
    vdes_r   <= vdes_nxt;
    verr_r   <= verr_nxt;
    cmd_r    <= cmd_nxt;
    satd_r   <= satd_nxt;
    out_r    <= out_nxt;
  end

  assign stat.item_op  = op_r;
  assign stat.mode     = mode_r;
  assign stat.mul_done = mul_done;
  assign stat.sat_hit  = sat_hi | sat_lo;
  assign out_data      = out_r;

endmodule

>>> hdl/cmlp_ctrl.sv
// Controller of the motor control loop: sequences the datapath through one
// request and owns the input ready and output valid handshake.
// Depends on cmlp_pkg.
module cmlp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  cmlp_pkg::ctl_stat_t stat,
  output cmlp_pkg::ctl_cmd_t  cmd
);

  cmlp_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;
  logic             loop_mode;

  assign out_free  = !out_valid_r || out_ready;
  // velocity loop runs for every mode from velocity upward
  assign loop_mode = stat.mode >= cmlp_pkg::MODE_VELOCITY;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cmlp_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = cmlp_pkg::ST_CLAMP;
      end
      cmlp_pkg::ST_CLAMP: begin
        if (stat.item_op == cmlp_pkg::OP_RESET) begin
          state_nxt = cmlp_pkg::ST_OUT;
        end else begin
          case (stat.mode) inside
            cmlp_pkg::MODE_CURRENT, cmlp_pkg::MODE_VELOCITY, cmlp_pkg::MODE_POSITION:
              state_nxt = cmlp_pkg::ST_SETPT;
            cmlp_pkg::MODE_CURRENT_RAMP, cmlp_pkg::MODE_VEL_RAMP:
              state_nxt = cmlp_pkg::ST_DIFF;
            default: state_nxt = cmlp_pkg::ST_PERR;
          endcase
        end
      end
      cmlp_pkg::ST_SETPT: begin
        case (stat.mode)
          cmlp_pkg::MODE_CURRENT:  state_nxt = cmlp_pkg::ST_SAT;
          cmlp_pkg::MODE_VELOCITY: state_nxt = cmlp_pkg::ST_VERR;
          default:                 state_nxt = cmlp_pkg::ST_PERR;
        endcase
      end
      cmlp_pkg::ST_DIFF: state_nxt = cmlp_pkg::ST_STEP;
      cmlp_pkg::ST_STEP: begin
        state_nxt = (stat.mode == cmlp_pkg::MODE_VEL_RAMP) ? cmlp_pkg::ST_FF_GO
                                                           : cmlp_pkg::ST_SAT;
      end
      cmlp_pkg::ST_FF_GO: state_nxt = cmlp_pkg::ST_FF_WAIT;
      cmlp_pkg::ST_FF_WAIT: begin
        if (stat.mul_done) state_nxt = cmlp_pkg::ST_VERR;
      end
      cmlp_pkg::ST_PERR:  state_nxt = cmlp_pkg::ST_PG_GO;
      cmlp_pkg::ST_PG_GO: state_nxt = cmlp_pkg::ST_PG_WAIT;
      cmlp_pkg::ST_PG_WAIT: begin
        if (stat.mul_done) state_nxt = cmlp_pkg::ST_VCLAMP;
      end
      cmlp_pkg::ST_VCLAMP: state_nxt = cmlp_pkg::ST_VERR;
      cmlp_pkg::ST_VERR:   state_nxt = cmlp_pkg::ST_VG_GO;
      cmlp_pkg::ST_VG_GO:  state_nxt = cmlp_pkg::ST_VG_WAIT;
      cmlp_pkg::ST_VG_WAIT: begin
        if (stat.mul_done) state_nxt = cmlp_pkg::ST_ADDI;
      end
      cmlp_pkg::ST_ADDI: state_nxt = cmlp_pkg::ST_SAT;
      cmlp_pkg::ST_SAT: begin
        // freeze the integrator while the command saturates
        state_nxt = (!stat.sat_hit && loop_mode) ? cmlp_pkg::ST_IG_GO : cmlp_pkg::ST_OUT;
      end
      cmlp_pkg::ST_IG_GO: state_nxt = cmlp_pkg::ST_IG_WAIT;
      cmlp_pkg::ST_IG_WAIT: begin
        if (stat.mul_done) state_nxt = cmlp_pkg::ST_OUT;
      end
      cmlp_pkg::ST_OUT: begin
        if (out_free) state_nxt = cmlp_pkg::ST_IDLE;
      end
      default: state_nxt = cmlp_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd.op      = cmlp_pkg::DP_NOP;
    cmd.sel_vel = (stat.mode == cmlp_pkg::MODE_VELOCITY) ||
                  (stat.mode == cmlp_pkg::MODE_VEL_RAMP);
    in_ready    = 1'b0;
    unique case (state_r)
      cmlp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = cmlp_pkg::DP_LOAD;
      end
      cmlp_pkg::ST_CLAMP: begin
        cmd.op = (stat.item_op == cmlp_pkg::OP_RESET) ? cmlp_pkg::DP_RESET_OP
                                                      : cmlp_pkg::DP_CLAMP;
      end
      cmlp_pkg::ST_SETPT:  cmd.op = cmlp_pkg::DP_SETPT;
      cmlp_pkg::ST_DIFF:   cmd.op = cmlp_pkg::DP_DIFF;
      cmlp_pkg::ST_STEP:   cmd.op = cmlp_pkg::DP_STEP;
      cmlp_pkg::ST_FF_GO:  cmd.op = cmlp_pkg::DP_FF_MUL;
      cmlp_pkg::ST_FF_WAIT: begin
        if (stat.mul_done) cmd.op = cmlp_pkg::DP_FF_WR;
      end
      cmlp_pkg::ST_PERR:   cmd.op = cmlp_pkg::DP_PERR;
      cmlp_pkg::ST_PG_GO:  cmd.op = cmlp_pkg::DP_PG_MUL;
      cmlp_pkg::ST_PG_WAIT: begin
        if (stat.mul_done) cmd.op = cmlp_pkg::DP_PG_WR;
      end
      cmlp_pkg::ST_VCLAMP: cmd.op = cmlp_pkg::DP_VCLAMP;
      cmlp_pkg::ST_VERR:   cmd.op = cmlp_pkg::DP_VERR;
      cmlp_pkg::ST_VG_GO:  cmd.op = cmlp_pkg::DP_VG_MUL;
      cmlp_pkg::ST_VG_WAIT: begin
        if (stat.mul_done) cmd.op = cmlp_pkg::DP_VG_WR;
      end
      cmlp_pkg::ST_ADDI:   cmd.op = cmlp_pkg::DP_ADD_INT;
      cmlp_pkg::ST_SAT:    cmd.op = cmlp_pkg::DP_SAT;
      cmlp_pkg::ST_IG_GO:  cmd.op = cmlp_pkg::DP_IG_MUL;
      cmlp_pkg::ST_IG_WAIT: begin
        if (stat.mul_done) cmd.op = cmlp_pkg::DP_IG_WR;
      end
      cmlp_pkg::ST_OUT: begin
        if (out_free) cmd.op = cmlp_pkg::DP_OUT;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (state_r == cmlp_pkg::ST_OUT && out_free) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cmlp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> hdl/cascaded_motor_control_loop.sv
// Cascaded position/velocity PI current controller, one request at a time.
// The shared multiplier takes one 16-bit digit per cycle, NDIG = ceil(VALUE_WIDTH/16)
// digits per product (2 at 32 bits), and serves up to three products per tick.
// Next request is taken the cycle after the result enters the output register.
// Synchronous active-low reset clears configuration registers, setpoints and integrator to zero.
module cascaded_motor_control_loop #(
  parameter int unsigned VALUE_WIDTH   = 32,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  cmlp_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output cmlp_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [cmlp_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [cmlp_pkg::CFG_W-1:0]     cfg_wdata
);

  cmlp_pkg::ctl_cmd_t  cmd;
  cmlp_pkg::ctl_stat_t stat;

  cmlp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cmlp_datapath #(
    .W (VALUE_WIDTH),
    .F (FRACTION_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_data)
  );

endmodule

>>> hdl/cmlp_checker.sv
// Port-level checks of the motor control loop, bound to the top level.
// Depends on cmlp_pkg and cascaded_motor_control_loop.
module cmlp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input cmlp_pkg::out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // one request in flight: ready drops right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in work");

  // no result appears the cycle after an accept
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result too early after accept");

  // nothing pending coming out of reset
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind cascaded_motor_control_loop cmlp_checker u_cmlp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
